[hdl/hmmu_pkg.sv]
// ----------------------------------------------------------------------------
// hmmu_pkg
// shared types and constants of the handheld memory map unit
// ----------------------------------------------------------------------------
package hmmu_pkg;

  localparam int unsigned ROM_BYTES_DEF = 32768;
  localparam int unsigned RAM_BYTES     = 8192;
  localparam int unsigned BOOT_BYTES    = 256;
  localparam int unsigned HIGH_BYTES    = 128;

  localparam int unsigned RAM_AW  = $clog2(RAM_BYTES);
  localparam int unsigned BOOT_AW = $clog2(BOOT_BYTES);
  localparam int unsigned HIGH_AW = $clog2(HIGH_BYTES);

  localparam logic [15:0] BOOT_EXIT_PC = 16'h0100;
  localparam logic [15:0] WORK_END     = 16'hFE00;
  localparam logic [15:0] HIGH_BASE    = 16'hFF80;

  typedef enum logic [2:0] {
    MODE_RD_BYTE   = 3'd0,
    MODE_WR_BYTE   = 3'd1,
    MODE_RD_WORD   = 3'd2,
    MODE_WR_WORD   = 3'd3,
    MODE_LOAD_BOOT = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    SRC_NONE,
    SRC_BOOT,
    SRC_ROM,
    SRC_EXT,
    SRC_WORK,
    SRC_HIGH
  } src_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LO,
    ST_HI,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic take;
    logic clear;
    logic issue;
    logic second;
    logic cap_lo;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic is_word;
  } sts_t;

endpackage

[hdl/hmmu_if.sv]
// ----------------------------------------------------------------------------
// hmmu_req_if / hmmu_rsp_if
// valid/ready channels for access requests and their results
// ----------------------------------------------------------------------------
interface hmmu_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic [15:0] address;
  logic [15:0] write_data;
  logic [15:0] cpu_pc;

  modport source (output valid, mode, address, write_data, cpu_pc, input ready);
  modport sink (input valid, mode, address, write_data, cpu_pc, output ready);
endinterface

interface hmmu_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] read_data;
  logic        overlay_on;

  modport source (output valid, read_data, overlay_on, input ready);
  modport sink (input valid, read_data, overlay_on, output ready);
endinterface

[hdl/hmmu_ctrl.sv]
// ----------------------------------------------------------------------------
// hmmu_ctrl
// sequencer for clearing pass, byte accesses and result hand-off
// ----------------------------------------------------------------------------
module hmmu_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output hmmu_pkg::cmd_t  cmd,
  input  hmmu_pkg::sts_t  sts
);
  import hmmu_pkg::*;

  state_t state;
  state_t state_next;
  logic   slot_free;
  logic   accept;

  assign slot_free = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (sts.clear_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) state_next = ST_LO;
      end
      ST_LO: begin
        state_next = sts.is_word ? ST_HI : ST_OUT;
      end
      ST_HI: begin
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (slot_free) state_next = accept ? ST_LO : ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_LO: begin
        cmd.issue = 1'b1;
      end
      ST_HI: begin
        cmd.issue  = 1'b1;
        cmd.second = 1'b1;
        cmd.cap_lo = 1'b1;
      end
      ST_OUT: begin
        cmd.load_out = slot_free;
        in_ready     = slot_free;
      end
      default: ;
    endcase
    cmd.take = in_valid && in_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[hdl/hmmu_dp.sv]
// ----------------------------------------------------------------------------
// hmmu_dp
// address decode, byte stores, boot overlay flag and result register
// ----------------------------------------------------------------------------
module hmmu_dp #(
  parameter int unsigned ROM_BYTES = hmmu_pkg::ROM_BYTES_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  hmmu_pkg::cmd_t  cmd,
  output hmmu_pkg::sts_t  sts,
  input  logic [2:0]      mode,
  input  logic [15:0]     address,
  input  logic [15:0]     write_data,
  input  logic [15:0]     cpu_pc,
  output logic [15:0]     read_data,
  output logic            overlay_on
);
  import hmmu_pkg::*;

  localparam int unsigned RomAw = $clog2(ROM_BYTES);
  localparam logic [15:0] RomSize = 16'(ROM_BYTES);
  localparam logic [RomAw-1:0] SweepLast = RomAw'(ROM_BYTES - 1);

  logic [7:0] boot_mem [BOOT_BYTES];
  logic [7:0] rom_mem  [ROM_BYTES];
  logic [7:0] ext_mem  [RAM_BYTES];
  logic [7:0] work_mem [RAM_BYTES];
  logic [7:0] high_mem [HIGH_BYTES];

  logic [2:0]  r_mode;
  logic [15:0] r_address;
  logic [15:0] r_write_data;
  logic [15:0] r_cpu_pc;
  logic        overlay;
  logic [RomAw-1:0] sweep;
  src_t        sel;
  logic [7:0]  lo_byte;

  logic [7:0]  boot_q, rom_q, ext_q, work_q, high_q;
  logic [7:0]  byte_q;

  logic        is_word, is_write, is_read, is_load;
  logic [15:0] a;
  logic [15:0] rom_lin;
  logic [RomAw-1:0] rom_idx;
  src_t        src;
  logic        clear_ov;
  logic [7:0]  wr_byte;
  logic        acc_wr, acc_rd;

  always_comb begin
    is_word  = 1'b0;
    is_write = 1'b0;
    is_read  = 1'b0;
    is_load  = 1'b0;
    case (r_mode)
      MODE_RD_BYTE:   is_read = 1'b1;
      MODE_WR_BYTE:   is_write = 1'b1;
      MODE_RD_WORD: begin
        is_read = 1'b1;
        is_word = 1'b1;
      end
      MODE_WR_WORD: begin
        is_write = 1'b1;
        is_word  = 1'b1;
      end
      MODE_LOAD_BOOT: is_load = 1'b1;
      default: ;
    endcase
  end

  assign sts.is_word    = is_word;
  assign sts.clear_last = (sweep == SweepLast);

  // byte address decode
  always_comb begin
    a        = cmd.second ? r_address + 16'd1 : r_address;
    rom_lin  = {1'b0, a[14:0]};
    if (rom_lin >= RomSize) rom_lin = rom_lin - RomSize;
    rom_idx  = rom_lin[RomAw-1:0];
    clear_ov = 1'b0;
    src      = SRC_NONE;
    if (a[15:12] == 4'h0 && overlay && a[15:8] == 8'h00) begin
      src = SRC_BOOT;
    end else begin
      if (a[15:12] == 4'h0 && overlay && a[15:8] != 8'h00 && r_cpu_pc == BOOT_EXIT_PC) begin
        clear_ov = 1'b1;
      end
      if (!a[15]) begin
        src = SRC_ROM;
      end else if (a[14:13] == 2'b01) begin
        src = SRC_EXT;
      end else if (a[14] && a < WORK_END) begin
        src = SRC_WORK;
      end else if (a >= HIGH_BASE) begin
        src = SRC_HIGH;
      end else begin
        src = SRC_NONE;
      end
    end
    wr_byte = cmd.second ? r_write_data[15:8] : r_write_data[7:0];
    acc_wr  = cmd.issue && is_write;
    acc_rd  = cmd.issue && is_read;
  end

  // byte stores
  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      boot_mem[sweep[BOOT_AW-1:0]] <= 8'h00;
    end else if (cmd.issue && is_load) begin
      boot_mem[r_address[BOOT_AW-1:0]] <= r_write_data[7:0];
    end else if (acc_wr && src == SRC_BOOT) begin
      boot_mem[a[BOOT_AW-1:0]] <= wr_byte;
    end
    if (acc_rd && src == SRC_BOOT) boot_q <= boot_mem[a[BOOT_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      rom_mem[sweep] <= 8'h00;
    end else if (acc_wr && src == SRC_ROM) begin
      rom_mem[rom_idx] <= wr_byte;
    end
    if (acc_rd && src == SRC_ROM) rom_q <= rom_mem[rom_idx];
  end

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      ext_mem[sweep[RAM_AW-1:0]] <= 8'h00;
    end else if (acc_wr && src == SRC_EXT) begin
      ext_mem[a[RAM_AW-1:0]] <= wr_byte;
    end
    if (acc_rd && src == SRC_EXT) ext_q <= ext_mem[a[RAM_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      work_mem[sweep[RAM_AW-1:0]] <= 8'h00;
    end else if (acc_wr && src == SRC_WORK) begin
      work_mem[a[RAM_AW-1:0]] <= wr_byte;
    end
    if (acc_rd && src == SRC_WORK) work_q <= work_mem[a[RAM_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      high_mem[sweep[HIGH_AW-1:0]] <= 8'h00;
    end else if (acc_wr && src == SRC_HIGH) begin
      high_mem[a[HIGH_AW-1:0]] <= wr_byte;
    end
    if (acc_rd && src == SRC_HIGH) high_q <= high_mem[a[HIGH_AW-1:0]];
  end

  always_comb begin
    case (sel)
      SRC_BOOT: byte_q = boot_q;
      SRC_ROM:  byte_q = rom_q;
      SRC_EXT:  byte_q = ext_q;
      SRC_WORK: byte_q = work_q;
      SRC_HIGH: byte_q = high_q;
      default:  byte_q = 8'h00;
    endcase
  end

  // request, overlay and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      overlay <= 1'b0;
      sweep   <= '0;
    end else begin
      if (cmd.clear) sweep <= sweep + RomAw'(1);
      if (cmd.issue && is_load) begin
        overlay <= 1'b1;
      end else if (cmd.issue && (is_read || is_write) && clear_ov) begin
        overlay <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      r_mode       <= mode;
      r_address    <= address;
      r_write_data <= write_data;
      r_cpu_pc     <= cpu_pc;
    end
    if (acc_rd) sel <= src;
    if (cmd.cap_lo) lo_byte <= byte_q;
    if (cmd.load_out) begin
      overlay_on <= overlay;
      if (!is_read) begin
        read_data <= 16'h0000;
      end else if (is_word) begin
        read_data <= {byte_q, lo_byte};
      end else begin
        read_data <= {8'h00, byte_q};
      end
    end
  end

endmodule

[hdl/handheld_memory_map_unit_core.sv]
// ----------------------------------------------------------------------------
// handheld_memory_map_unit_core
// 16-bit cpu memory map with boot overlay, rom, external, work and high ram
// ----------------------------------------------------------------------------
// After reset the block sweeps all byte stores to zero, one address per
// cycle, with req.ready low. Each store is a single-port memory, so one
// byte is touched per cycle: a byte access, boot load or unknown mode
// steps through ST_LO and ST_OUT, a word access through ST_LO, ST_HI and
// ST_OUT. A new request is accepted in the same cycle a result is loaded
// into the output register, so requests run back to back while rsp is free.
module handheld_memory_map_unit_core #(
  parameter int unsigned ROM_BYTES = hmmu_pkg::ROM_BYTES_DEF
) (
  input logic       clk,
  input logic       rst,
  hmmu_req_if.sink  req,
  hmmu_rsp_if.source rsp
);
  import hmmu_pkg::*;

  cmd_t cmd;
  sts_t sts;

  hmmu_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  hmmu_dp #(
    .ROM_BYTES (ROM_BYTES)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .mode       (req.mode),
    .address    (req.address),
    .write_data (req.write_data),
    .cpu_pc     (req.cpu_pc),
    .read_data  (rsp.read_data),
    .overlay_on (rsp.overlay_on)
  );

endmodule
